// File: rtl/core/ttcw_pkg.sv
package ttcw_pkg;

	localparam int CELL_W = 16;
	localparam logic [7:0] CR_CODE = 8'd13;
	localparam logic [CELL_W-1:0] RESET_CELL = 16'h2020;

	localparam logic [7:0] RST_COLUMNS = 8'd80;
	localparam logic [6:0] RST_ROWS = 7'd25;
	localparam logic [7:0] RST_NEWLINE = 8'd10;
	localparam logic [7:0] RST_DELETE = 8'd127;
	localparam logic [7:0] RST_BLANK = 8'd32;

	typedef enum logic [2:0] {
		CFG_COLUMNS = 3'd0,
		CFG_ROWS = 3'd1,
		CFG_NEWLINE = 3'd2,
		CFG_DELETE = 3'd3,
		CFG_BLANK = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_PUT_CHAR = 3'd0,
		OP_PUT_AT = 3'd1,
		OP_MOVE = 3'd2,
		OP_CLEAR = 3'd3,
		OP_SET_COLOR = 3'd4,
		OP_READ = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL,
		ST_CLEAR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [7:0] newline_code;
		logic [7:0] delete_code;
		logic [7:0] blank_code;
	} codes_t;

	typedef struct packed {
		logic [7:0] color_in;
		logic [6:0] pos_y;
		logic [7:0] pos_x;
		logic [7:0] ch;
		op_t op;
	} in_word_t;

	typedef struct packed {
		logic did_scroll;
		logic [7:0] cell_color;
		logic [7:0] cell_char;
		logic [5:0] cursor_row;
		logic [6:0] cursor_col;
	} out_word_t;

endpackage

// File: rtl/core/ttcw_mem.sv
module ttcw_mem
	import ttcw_pkg::*;
#(
	parameter int DEPTH = 8192,
	parameter int AW = 13
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [CELL_W-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/ttcw_ctrl.sv
module ttcw_ctrl
	import ttcw_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int CNTW = 8,
	parameter int HW = 7,
	parameter int AW = 13
) (
	input logic clk,
	input logic arst_n,
	input logic [CNTW-1:0] act_w,
	input logic [HW-1:0] act_h,
	input codes_t codes,
	input logic in_valid,
	output logic in_ready,
	input in_word_t in_word,
	input logic out_free,
	output logic fin_valid,
	output out_word_t fin_word,
	output logic mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [CELL_W-1:0] mem_wdata,
	output logic mem_re,
	output logic [AW-1:0] mem_raddr,
	input logic [CELL_W-1:0] mem_rdata
);

	localparam int XW = $clog2(MAX_COLS);
	localparam int YW = $clog2(MAX_ROWS);
	localparam int STORE = MAX_COLS * MAX_ROWS;

	state_t state_q, state_d;
	logic [AW-1:0] j_q;
	op_t op_q;
	logic [7:0] ch_q;
	logic [7:0] color_in_q;
	logic [XW-1:0] px_q;
	logic [YW-1:0] py_q;
	logic [XW-1:0] cur_x_q;
	logic [YW-1:0] cur_y_q;
	logic [7:0] color_q;
	logic scrolled_q;
	logic [AW-1:0] area_m1_q;
	logic [AW-1:0] last_q;
	logic wr_s1;
	logic [AW-1:0] waddr_s1;
	logic blank_s1;

	logic [XW-1:0] w_m1;
	logic [YW-1:0] h_m1;
	logic [XW-1:0] in_px, clamp_x, bs_x, tx, nx_x;
	logic [YW-1:0] in_py, clamp_y, bs_y, ty, nx_y;
	logic [AW-1:0] cell_addr;
	logic [CNTW-1:0] inc_x;
	logic is_del, is_cr, wrap, row_ok, scroll_now;
	logic [CELL_W-1:0] blank_cell;

	assign w_m1 = XW'(act_w - CNTW'(1));
	assign h_m1 = YW'(act_h - HW'(1));
	assign blank_cell = {codes.blank_code, codes.blank_code};

	// coordinate saturation, negative means last
	always_comb begin
		if (in_word.pos_x[7] || (9'(in_word.pos_x) >= 9'(act_w))) begin
			in_px = w_m1;
		end else begin
			in_px = XW'(in_word.pos_x);
		end
		if (in_word.pos_y[6] || (8'(in_word.pos_y) >= 8'(act_h))) begin
			in_py = h_m1;
		end else begin
			in_py = YW'(in_word.pos_y);
		end
		clamp_x = (CNTW'(cur_x_q) >= act_w) ? w_m1 : cur_x_q;
		clamp_y = (HW'(cur_y_q) >= act_h) ? h_m1 : cur_y_q;
	end

	always_comb begin
		is_del = (ch_q == codes.delete_code);
		is_cr = (ch_q == CR_CODE);
		if (cur_x_q != '0) begin
			bs_x = cur_x_q - XW'(1);
			bs_y = cur_y_q;
		end else if (cur_y_q != '0) begin
			bs_x = w_m1;
			bs_y = cur_y_q - YW'(1);
		end else begin
			bs_x = '0;
			bs_y = '0;
		end
		if (op_q == OP_PUT_CHAR) begin
			tx = is_del ? bs_x : cur_x_q;
			ty = is_del ? bs_y : cur_y_q;
		end else begin
			tx = px_q;
			ty = py_q;
		end
		cell_addr = AW'(ty) * AW'(act_w) + AW'(tx);
		inc_x = CNTW'(cur_x_q) + CNTW'(1);
		wrap = (inc_x == act_w) || (ch_q == codes.newline_code);
		row_ok = (HW'(cur_y_q) + HW'(1)) < act_h;
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = '0;
		fin_valid = 1'b0;
		fin_word.cursor_col = 7'(cur_x_q);
		fin_word.cursor_row = 6'(cur_y_q);
		fin_word.cell_char = '0;
		fin_word.cell_color = '0;
		fin_word.did_scroll = scrolled_q;
		nx_x = cur_x_q;
		nx_y = cur_y_q;
		scroll_now = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_waddr = j_q;
				mem_wdata = RESET_CELL;
				if (j_q == AW'(STORE - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_PUT_CHAR: begin
						if (is_del) begin
							mem_we = 1'b1;
							mem_waddr = cell_addr;
							mem_wdata = blank_cell;
							nx_x = bs_x;
							nx_y = bs_y;
						end else if (is_cr) begin
							nx_x = '0;
						end else begin
							mem_we = 1'b1;
							mem_waddr = cell_addr;
							mem_wdata = {color_q, ch_q};
							if (wrap) begin
								nx_x = '0;
								if (row_ok) begin
									nx_y = cur_y_q + YW'(1);
								end else begin
									scroll_now = 1'b1;
								end
							end else begin
								nx_x = XW'(inc_x);
							end
						end
					end
					OP_PUT_AT: begin
						mem_we = 1'b1;
						mem_waddr = cell_addr;
						mem_wdata = {color_in_q, ch_q};
					end
					OP_MOVE: begin
						nx_x = px_q;
						nx_y = py_q;
					end
					OP_CLEAR: begin
						nx_x = '0;
						nx_y = '0;
					end
					OP_READ: begin
						mem_re = 1'b1;
						mem_raddr = cell_addr;
					end
					default: begin
					end
				endcase
				if (scroll_now) begin
					state_d = ST_SCROLL;
				end else if (op_q == OP_CLEAR) begin
					state_d = ST_CLEAR;
				end else if (op_q == OP_READ) begin
					state_d = ST_READ;
				end else begin
					fin_valid = 1'b1;
					fin_word.cursor_col = 7'(nx_x);
					fin_word.cursor_row = 6'(nx_y);
					fin_word.did_scroll = 1'b0;
					state_d = out_free ? ST_IDLE : ST_FIN;
				end
			end
			ST_READ: begin
				fin_valid = 1'b1;
				fin_word.cell_char = mem_rdata[7:0];
				fin_word.cell_color = mem_rdata[15:8];
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCROLL: begin
				mem_re = 1'b1;
				mem_raddr = AW'((AW + 1)'(j_q) + (AW + 1)'(act_w));
				if (j_q == area_m1_q) begin
					state_d = ST_FIN;
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = j_q;
				mem_wdata = {ch_q, ch_q};
				if (j_q == area_m1_q) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				fin_valid = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// delayed write of the row move
		if (wr_s1) begin
			mem_we = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = blank_s1 ? blank_cell : mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			color_q <= '0;
			scrolled_q <= 1'b0;
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= (state_q == ST_SCROLL);
			if (state_q == ST_INIT || state_q == ST_SCROLL || state_q == ST_CLEAR) begin
				j_q <= j_q + AW'(1);
			end
			if (state_q == ST_IDLE && in_valid) begin
				cur_x_q <= clamp_x;
				cur_y_q <= clamp_y;
			end
			if (state_q == ST_EXEC) begin
				j_q <= '0;
				cur_x_q <= nx_x;
				cur_y_q <= nx_y;
				scrolled_q <= scroll_now;
				if (op_q == OP_SET_COLOR) begin
					color_q <= color_in_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q <= in_word.op;
			ch_q <= in_word.ch;
			color_in_q <= in_word.color_in;
			px_q <= in_px;
			py_q <= in_py;
		end
		waddr_s1 <= j_q;
		blank_s1 <= (j_q >= last_q);
		area_m1_q <= AW'((AW + 1)'(act_h) * (AW + 1)'(act_w) - (AW + 1)'(1));
		last_q <= AW'((AW + 1)'(act_h - HW'(1)) * (AW + 1)'(act_w));
	end

endmodule

// File: rtl/core/text_terminal_cell_writer.sv
// flow: the controller accepts a word in its idle state and handles it in the execute state;
// read cell adds a read-data state; clear and a scrolling put char step through all columns*rows cells.
// s_axis_tready is high only in the idle state, so no new word is taken until the last one is done
// and its result has been handed to the output register.
// reset: asynchronous; a clearing pass then writes every one of the MAX_COLS*MAX_ROWS
// cells to code 32 / color 32 with s_axis_tready held low
module text_terminal_cell_writer
	import ttcw_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [39:0] s_axis_tdata, // op, ch, pos_x, pos_y, color_in
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // cursor_col, cursor_row, cell_char, cell_color, did_scroll
	input logic cfg_we,
	input logic [2:0] cfg_addr,
	input logic [7:0] cfg_wdata
);

	localparam int CNTW = $clog2(MAX_COLS + 1);
	localparam int HW = $clog2(MAX_ROWS + 1);
	localparam int AW = $clog2(MAX_COLS * MAX_ROWS);

	logic [7:0] columns_q;
	logic [6:0] rows_q;
	codes_t codes_q;
	logic [CNTW-1:0] act_w;
	logic [HW-1:0] act_h;
	in_word_t in_word;
	logic fin_valid;
	out_word_t fin_word;
	out_word_t out_q;
	logic out_valid_q;
	logic out_free;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= RST_COLUMNS;
			rows_q <= RST_ROWS;
			codes_q.newline_code <= RST_NEWLINE;
			codes_q.delete_code <= RST_DELETE;
			codes_q.blank_code <= RST_BLANK;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_COLUMNS: columns_q <= cfg_wdata;
				CFG_ROWS: rows_q <= cfg_wdata[6:0];
				CFG_NEWLINE: codes_q.newline_code <= cfg_wdata;
				CFG_DELETE: codes_q.delete_code <= cfg_wdata;
				CFG_BLANK: codes_q.blank_code <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// active area saturated to 1..max
	always_comb begin
		if (columns_q == '0) begin
			act_w = CNTW'(1);
		end else if (9'(columns_q) > 9'(MAX_COLS)) begin
			act_w = CNTW'(MAX_COLS);
		end else begin
			act_w = CNTW'(columns_q);
		end
		if (rows_q == '0) begin
			act_h = HW'(1);
		end else if (8'(rows_q) > 8'(MAX_ROWS)) begin
			act_h = HW'(MAX_ROWS);
		end else begin
			act_h = HW'(rows_q);
		end
	end

	assign in_word = in_word_t'(s_axis_tdata[33:0]);

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fin_valid) begin
			out_q <= fin_word;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, out_q};

	ttcw_ctrl #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.CNTW(CNTW),
		.HW(HW),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.act_w(act_w),
		.act_h(act_h),
		.codes(codes_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_word(in_word),
		.out_free(out_free),
		.fin_valid(fin_valid),
		.fin_word(fin_word),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ttcw_mem #(
		.DEPTH(MAX_COLS * MAX_ROWS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import ttcw_pkg::*;

	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 64;
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int PROBE_COUNT = 24;
	localparam int PHASES = 14;
	localparam int LONG_HOLD = 400;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] ch;
		logic [7:0] px;
		logic [6:0] py;
		logic [7:0] color;
		logic typed;
		logic [6:0] col;
		logic [5:0] row;
		logic [7:0] chr;
		logic [7:0] clr;
		logic scr;
	} probe_t;

	// op, ch, x, y, color, typed, then cursor col/row, char, color, scroll
	localparam probe_t PROBES [PROBE_COUNT] = '{
		'{OP_READ, 8'h00, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd0, 8'h20, 8'h20, 1'b0},
		'{OP_SET_COLOR, 8'h00, 8'h00, 7'h00, 8'hFF, 1'b1, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_PUT_CHAR, 8'h41, 8'h00, 7'h00, 8'h00, 1'b1, 7'd1, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_PUT_CHAR, 8'h0D, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_PUT_CHAR, 8'h7F, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_READ, 8'h00, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd0, 8'h20, 8'h20, 1'b0},
		'{OP_PUT_CHAR, 8'h0A, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd1, 8'h00, 8'h00, 1'b0},
		'{OP_PUT_CHAR, 8'h7F, 8'h00, 7'h00, 8'h00, 1'b1, 7'd79, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_READ, 8'h00, 8'hFF, 7'h7F, 8'h00, 1'b1, 7'd79, 6'd0, 8'h20, 8'h20, 1'b0},
		'{OP_MOVE, 8'h00, 8'h7F, 7'h3F, 8'h00, 1'b1, 7'd79, 6'd24, 8'h00, 8'h00, 1'b0},
		'{OP_PUT_CHAR, 8'hFF, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd24, 8'h00, 8'h00, 1'b1},
		'{OP_READ, 8'h00, 8'h7F, 7'h17, 8'h00, 1'b0, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_PUT_AT, 8'h00, 8'h80, 7'h00, 8'h00, 1'b1, 7'd0, 6'd24, 8'h00, 8'h00, 1'b0},
		'{OP_READ, 8'h00, 8'h80, 7'h00, 8'h00, 1'b0, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_SPARE_6, 8'h00, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd24, 8'h00, 8'h00, 1'b0},
		'{OP_SPARE_7, 8'hFF, 8'hFF, 7'h7F, 8'hFF, 1'b1, 7'd0, 6'd24, 8'h00, 8'h00, 1'b0},
		'{OP_MOVE, 8'h00, 8'h00, 7'h40, 8'h00, 1'b1, 7'd0, 6'd24, 8'h00, 8'h00, 1'b0},
		'{OP_PUT_CHAR, 8'h00, 8'h00, 7'h00, 8'h00, 1'b0, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_CLEAR, 8'hFF, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_READ, 8'h00, 8'h05, 7'h05, 8'h00, 1'b0, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_PUT_AT, 8'hAA, 8'h4F, 7'h18, 8'h55, 1'b1, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_READ, 8'h00, 8'h4F, 7'h18, 8'h00, 1'b0, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_CLEAR, 8'h00, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0},
		'{OP_SET_COLOR, 8'h00, 8'h00, 7'h00, 8'h00, 1'b1, 7'd0, 6'd0, 8'h00, 8'h00, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0; // op, ch, pos_x, pos_y, color_in
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata; // cursor_col, cursor_row, cell_char, cell_color, did_scroll
	logic cfg_we = 1'b0;
	logic [2:0] cfg_addr = '0;
	logic [7:0] cfg_wdata = '0;

	logic [7:0] glyph [CELLS];
	logic [7:0] tint [CELLS];
	int cur_x, cur_y;
	logic [7:0] cur_color;
	logic [7:0] reg_columns, reg_newline, reg_delete, reg_blank;
	logic [6:0] reg_rows;

	out_word_t awaited_status [$];
	int fail_count = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit long_hold_req = 1'b0;

	text_terminal_cell_writer #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int act_columns();
		if (reg_columns == 0) return 1;
		return (reg_columns > MAX_COLS) ? MAX_COLS : int'(reg_columns);
	endfunction

	function automatic int act_rows();
		if (reg_rows == 0) return 1;
		return (reg_rows > MAX_ROWS) ? MAX_ROWS : int'(reg_rows);
	endfunction

	function automatic out_word_t apply_terminal_op(input logic [2:0] op, input logic [7:0] ch,
			input logic [7:0] px_raw, input logic [6:0] py_raw, input logic [7:0] color);
		int w, h, px, py, a;
		out_word_t res;
		w = act_columns();
		h = act_rows();
		px = (px_raw[7] || px_raw >= w) ? w - 1 : int'(px_raw);
		py = (py_raw[6] || py_raw >= h) ? h - 1 : int'(py_raw);
		res = '0;
		if (cur_x >= w) cur_x = w - 1;
		if (cur_y >= h) cur_y = h - 1;
		case (op)
			OP_PUT_CHAR: begin
				if (ch == reg_delete) begin
					if (cur_x > 0) begin
						cur_x--;
					end else if (cur_y > 0) begin
						cur_y--;
						cur_x = w - 1;
					end
					a = cur_x + cur_y * w;
					glyph[a] = reg_blank;
					tint[a] = reg_blank;
				end else if (ch == CR_CODE) begin
					cur_x = 0;
				end else begin
					a = cur_x + cur_y * w;
					glyph[a] = ch;
					tint[a] = cur_color;
					cur_x++;
					if (cur_x >= w || ch == reg_newline) begin
						cur_x = 0;
						if (cur_y + 1 < h) begin
							cur_y++;
						end else begin
							for (int i = 0; i < (h - 1) * w; i++) begin
								glyph[i] = glyph[i + w];
								tint[i] = tint[i + w];
							end
							for (int i = (h - 1) * w; i < h * w; i++) begin
								glyph[i] = reg_blank;
								tint[i] = reg_blank;
							end
							res.did_scroll = 1'b1;
						end
					end
				end
			end
			OP_PUT_AT: begin
				a = px + py * w;
				glyph[a] = ch;
				tint[a] = color;
			end
			OP_MOVE: begin
				cur_x = px;
				cur_y = py;
			end
			OP_CLEAR: begin
				for (int i = 0; i < w * h; i++) begin
					glyph[i] = ch;
					tint[i] = ch;
				end
				cur_x = 0;
				cur_y = 0;
			end
			OP_SET_COLOR: begin
				cur_color = color;
			end
			OP_READ: begin
				a = px + py * w;
				res.cell_char = glyph[a];
				res.cell_color = tint[a];
			end
			default: begin
			end
		endcase
		res.cursor_col = 7'(cur_x);
		res.cursor_row = 6'(cur_y);
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [2:0] pick_op(input logic big);
		int r;
		r = $urandom_range(0, 99);
		if (r < (big ? 45 : 50)) return OP_PUT_CHAR;
		if (r < 58) return OP_PUT_AT;
		if (r < 66) return OP_MOVE;
		if (r < (big ? 67 : 69)) return OP_CLEAR;
		if (r < 76) return OP_SET_COLOR;
		if (r < 96) return OP_READ;
		return r[0] ? OP_SPARE_7 : OP_SPARE_6;
	endfunction

	task automatic offer_command(input logic [2:0] op, input logic [7:0] ch,
			input logic [7:0] px, input logic [6:0] py, input logic [7:0] color,
			input logic typed, input out_word_t typed_word);
		int gap;
		out_word_t predicted;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, color, py, px, ch, op};
		do @(posedge clk); while (!s_axis_tready);
		predicted = apply_terminal_op(op, ch, px, py, color);
		awaited_status.push_back(typed ? typed_word : predicted);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_COLUMNS: reg_columns = data;
			CFG_ROWS: reg_rows = data[6:0];
			CFG_NEWLINE: reg_newline = data;
			CFG_DELETE: reg_delete = data;
			CFG_BLANK: reg_blank = data;
			default: begin
			end
		endcase
	endtask

	task automatic program_registers(input logic [7:0] cols, input logic [7:0] rws,
			input logic [7:0] nl, input logic [7:0] del, input logic [7:0] blank);
		s_axis_tvalid <= 1'b0;
		while (awaited_status.size() != 0 || !s_axis_tready) @(posedge clk);
		write_reg(CFG_COLUMNS, cols);
		write_reg(CFG_ROWS, rws);
		write_reg(CFG_NEWLINE, nl);
		write_reg(CFG_DELETE, del);
		write_reg(CFG_BLANK, blank);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		out_word_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[29:0];
			if (awaited_status.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected word %h", m_axis_tdata);
			end else begin
				want = awaited_status.pop_front();
				if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
						got.cell_char !== want.cell_char || got.cell_color !== want.cell_color ||
						got.did_scroll !== want.did_scroll) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch exp col %0d row %0d chr %h clr %h scr %b, got %0d %0d %h %h %b",
							want.cursor_col, want.cursor_row, want.cell_char, want.cell_color,
							want.did_scroll, got.cursor_col, got.cursor_row, got.cell_char,
							got.cell_color, got.did_scroll);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [2:0] op;
		logic [7:0] ch, px, color;
		logic [6:0] py;
		logic big;
		int w, h, r, count;
		out_word_t typed_word;
		for (int i = 0; i < CELLS; i++) begin
			glyph[i] = RST_BLANK;
			tint[i] = RST_BLANK;
		end
		cur_x = 0;
		cur_y = 0;
		cur_color = '0;
		reg_columns = RST_COLUMNS;
		reg_rows = RST_ROWS;
		reg_newline = RST_NEWLINE;
		reg_delete = RST_DELETE;
		reg_blank = RST_BLANK;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PROBE_COUNT; i++) begin
			typed_word = '0;
			typed_word.cursor_col = PROBES[i].col;
			typed_word.cursor_row = PROBES[i].row;
			typed_word.cell_char = PROBES[i].chr;
			typed_word.cell_color = PROBES[i].clr;
			typed_word.did_scroll = PROBES[i].scr;
			offer_command(PROBES[i].op, PROBES[i].ch, PROBES[i].px, PROBES[i].py,
				PROBES[i].color, PROBES[i].typed, typed_word);
		end

		for (int p = 0; p < PHASES; p++) begin
			big = 1'b0;
			calm = (p == 3 || p == 7 || p == 11);
			case (p)
				0: program_registers(8'd1, 8'd1, 8'd0, 8'hFF, 8'h00);
				1: program_registers(8'd0, 8'd0, 8'hFF, 8'h00, 8'hFF);
				2: begin
					big = 1'b1;
					program_registers(8'd128, 8'd64, RST_NEWLINE, RST_DELETE, RST_BLANK);
				end
				4: begin
					big = 1'b1;
					program_registers(8'hFF, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom));
				end
				default: program_registers(8'($urandom_range(1, 24)),
					8'($urandom_range(1, 12) | ($urandom_range(0, 1) << 7)),
					8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			// hold the result side off while commands keep coming
			if (p == 3)
				long_hold_req = 1'b1;
			count = big ? 35 : 130;
			w = act_columns();
			h = act_rows();
			for (int n = 0; n < count; n++) begin
				op = pick_op(big);
				r = $urandom_range(0, 99);
				if (op == OP_PUT_CHAR && r < 18)
					ch = reg_delete;
				else if (op == OP_PUT_CHAR && r < 28)
					ch = CR_CODE;
				else if (op == OP_PUT_CHAR && r < 43)
					ch = reg_newline;
				else
					ch = 8'($urandom);
				case ($urandom_range(0, 4))
					0: px = 8'hFF;
					1: px = 8'($urandom_range(128, 255));
					2, 3: px = 8'($urandom_range(0, w - 1));
					default: px = 8'($urandom_range(0, 127));
				endcase
				case ($urandom_range(0, 4))
					0: py = 7'h7F;
					1: py = 7'($urandom_range(64, 127));
					2, 3: py = 7'($urandom_range(0, h - 1));
					default: py = 7'($urandom_range(0, 63));
				endcase
				color = 8'($urandom);
				offer_command(op, ch, px, py, color, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		calm = 1'b0;
		while (awaited_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
